@@ design/votp_pkg.sv @@
// Shared types and constants for the vendor option TLV parser.
`timescale 1ns / 1ps

package votp_pkg;

   // Bytes in the enterprise number and in one sub-option header
   localparam logic [15:0] HDR_BYTES = 16'd4;

   // Result kinds
   localparam logic [1:0] KIND_ENT  = 2'd0;
   localparam logic [1:0] KIND_HDR  = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;
   localparam logic [1:0] KIND_END  = 2'd3;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_BOUNDS   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG = 3'd3;
   localparam logic [2:0] ST_MISMATCH = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_EXPECTED_ENT = 2'd0;
   localparam logic [1:0] CSR_MAX_SUB_LEN  = 2'd1;
   localparam logic [1:0] CSR_MAX_SUB_OPTS = 2'd2;

   typedef struct packed {
      logic        start_req;
      logic [7:0]  data_byte;
      logic [15:0] option_len;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ent_number;
      logic [15:0] sub_code;
      logic [15:0] sub_len;
      logic [7:0]  sub_index;
      logic [15:0] byte_offset;
      logic [7:0]  out_byte;
      logic        done_res;
      logic [2:0]  status;
   } rsp_type;

endpackage

@@ design/vendor_option_tlv_parser_core.sv @@
// Top level: byte-serial parser for a vendor-specific option payload.
//
//   channel  direction  ports                              moves
//   req      in         req_valid, req_stall, req_data     one payload byte
//   rsp      out        rsp_valid, rsp_stall, rsp_data     one parse result
//   csr      in         csr_write_en, csr_index, csr_wdata register write
//
// One byte per cycle while req_stall is low: each accepted byte updates the parse
// state and yields at most one result, registered in the output stage.
// A two-entry output buffer (main register plus skid) lets a byte enter while a
// result waits; req_stall rises only once both entries are full.
// Reset is synchronous; it clears the parse state and the buffer and sets the registers to their defaults.
`timescale 1ns / 1ps

module vendor_option_tlv_parser_core
   import votp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ENT,
      PH_HDR,
      PH_DATA,
      PH_SKIP
   } phase_type;

   // configuration
   logic [31:0] exp_ent_ff;
   logic [15:0] max_len_ff;
   logic [7:0]  max_opts_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] tl_ff, tl_in;
   logic [31:0] ent_ff, ent_in;
   logic [31:0] cls_ff, cls_in;
   logic [15:0] drem_ff, drem_in;
   logic [7:0]  scnt_ff, scnt_in;
   logic [2:0]  err_ff, err_in;
   logic        sup_ff, sup_in;

   // output buffer
   rsp_type     main_ff, skid_ff, rsp_in;
   logic        main_valid_ff, skid_valid_ff;

   logic        accept, drain, emit;
   logic        have, last, final_c;
   logic [15:0] pos_n, rem_n, drem_n;
   logic [7:0]  scnt_n;
   logic [2:0]  st;
   logic [1:0]  kind;
   logic [15:0] code, len, off;
   logic [7:0]  idx, ob;

   // Phase after one sub-option ends (or after the enterprise number)
   function automatic phase_type next_sub(input logic [15:0] pos, input logic [15:0] tl,
                                          input logic [15:0] rem, input logic [7:0] cnt,
                                          input logic [7:0] max_opts);
      phase_type ph;
      if (pos >= tl) begin
         ph = PH_IDLE;
      end else if (cnt >= max_opts || rem < HDR_BYTES) begin
         ph = PH_SKIP;
      end else begin
         ph = PH_HDR;
      end
      return ph;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign drain     = main_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      tl_in    = tl_ff;
      ent_in   = ent_ff;
      cls_in   = cls_ff;
      drem_in  = drem_ff;
      scnt_in  = scnt_ff;
      err_in   = err_ff;
      sup_in   = sup_ff;
      final_c  = 1'b0;
      have     = 1'b0;
      last     = 1'b0;
      kind     = KIND_ENT;
      code     = '0;
      len      = '0;
      off      = '0;
      idx      = '0;
      ob       = '0;
      drem_n   = '0;
      scnt_n   = '0;

      if (req_data.start_req) begin
         phase_in = PH_ENT;
         pos_in   = '0;
         tl_in    = req_data.option_len;
         ent_in   = '0;
         cls_in   = '0;
         drem_in  = '0;
         scnt_in  = '0;
         err_in   = ST_OK;
         sup_in   = 1'b0;
         if (req_data.option_len < HDR_BYTES) begin
            err_in  = ST_SHORT;
            final_c = 1'b1;
         end
      end

      pos_n = pos_in + 16'd1;
      rem_n = tl_in - pos_n;

      if (!final_c && phase_in != PH_IDLE) begin
         last = (pos_n == tl_in);
         case (phase_in)
            PH_ENT: begin
               ent_in = {ent_in[23:0], req_data.data_byte};
               if (pos_n == HDR_BYTES) begin
                  if (exp_ent_ff != '0 && ent_in != exp_ent_ff) begin
                     sup_in = 1'b1;
                  end
                  have     = 1'b1;
                  kind     = KIND_ENT;
                  phase_in = next_sub(pos_n, tl_in, rem_n, scnt_in, max_opts_ff);
                  cls_in   = '0;
                  drem_in  = '0;
               end
            end
            PH_HDR: begin
               cls_in  = {cls_in[23:0], req_data.data_byte};
               drem_n  = drem_in + 16'd1;
               drem_in = drem_n;
               if (drem_n >= HDR_BYTES) begin
                  code = cls_in[31:16];
                  len  = cls_in[15:0];
                  if (len > rem_n) begin
                     err_in = ST_BOUNDS;
                     last   = 1'b1;
                  end else if (len > max_len_ff) begin
                     err_in = ST_TOO_LONG;
                     last   = 1'b1;
                  end else begin
                     have = 1'b1;
                     kind = KIND_HDR;
                     idx  = scnt_in;
                     if (len == '0) begin
                        scnt_n   = scnt_in + 8'd1;
                        scnt_in  = scnt_n;
                        phase_in = next_sub(pos_n, tl_in, rem_n, scnt_n, max_opts_ff);
                        cls_in   = '0;
                        drem_in  = '0;
                     end else begin
                        drem_in  = len;
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               code    = cls_in[31:16];
               len     = cls_in[15:0];
               off     = len - drem_in;
               idx     = scnt_in;
               ob      = req_data.data_byte;
               have    = 1'b1;
               kind    = KIND_DATA;
               drem_n  = drem_in - 16'd1;
               drem_in = drem_n;
               if (drem_n == '0) begin
                  scnt_n   = scnt_in + 8'd1;
                  scnt_in  = scnt_n;
                  phase_in = next_sub(pos_n, tl_in, rem_n, scnt_n, max_opts_ff);
                  cls_in   = '0;
                  drem_in  = '0;
               end
            end
            default: begin
               // skipping a short tail or bytes past the sub-option limit
            end
         endcase
         pos_in  = pos_n;
         final_c = last;
      end

      // Error takes precedence over mismatch on the final result
      if (err_in != ST_OK) begin
         st = err_in;
      end else if (sup_in) begin
         st = ST_MISMATCH;
      end else begin
         st = ST_OK;
      end

      rsp_in.kind        = kind;
      rsp_in.ent_number  = ent_in;
      rsp_in.sub_code    = code;
      rsp_in.sub_len     = len;
      rsp_in.sub_index   = idx;
      rsp_in.byte_offset = off;
      rsp_in.out_byte    = ob;
      rsp_in.done_res    = 1'b0;
      rsp_in.status      = ST_OK;
      emit               = have && !sup_in;

      if (final_c) begin
         phase_in        = PH_IDLE;
         emit            = 1'b1;
         rsp_in.done_res = 1'b1;
         rsp_in.status   = st;
         if (pos_in < HDR_BYTES) begin
            rsp_in.ent_number = '0;
         end
         if (!have || st != ST_OK) begin
            rsp_in.kind        = KIND_END;
            rsp_in.sub_code    = '0;
            rsp_in.sub_len     = '0;
            rsp_in.sub_index   = '0;
            rsp_in.byte_offset = '0;
            rsp_in.out_byte    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ent_ff    <= '0;
         max_len_ff    <= 16'd256;
         max_opts_ff   <= 8'd16;
         phase_ff      <= PH_IDLE;
         pos_ff        <= '0;
         tl_ff         <= '0;
         ent_ff        <= '0;
         cls_ff        <= '0;
         drem_ff       <= '0;
         scnt_ff       <= '0;
         err_ff        <= ST_OK;
         sup_ff        <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_EXPECTED_ENT: exp_ent_ff  <= csr_wdata;
               CSR_MAX_SUB_LEN:  max_len_ff  <= csr_wdata[15:0];
               CSR_MAX_SUB_OPTS: max_opts_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end

         if (accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            tl_ff    <= tl_in;
            ent_ff   <= ent_in;
            cls_ff   <= cls_in;
            drem_ff  <= drem_in;
            scnt_ff  <= scnt_in;
            err_ff   <= err_in;
            sup_ff   <= sup_in;
         end

         if (skid_valid_ff) begin
            if (drain) begin
               main_ff       <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && emit) begin
            if (!main_valid_ff || drain) begin
               main_ff       <= rsp_in;
               main_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= rsp_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (drain) begin
            main_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ design/votp_checker.sv @@
// Port-level checks for the vendor option TLV parser, bound to the top level.
`timescale 1ns / 1ps

module votp_checker
   import votp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // output buffer comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // only the final result of an option carries a status
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == ST_OK)
      else $error("status on a non-final result");

   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.kind == KIND_END)
      else $error("error status without end kind");

   a_end_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_END |-> rsp_data.done_res)
      else $error("end-only result not marked done");

endmodule

bind vendor_option_tlv_parser_core votp_checker u_votp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ verif/tb_vendor_option_tlv_parser_core.sv @@
// Self-checking testbench for the vendor option TLV parser: byte-level predictor and random traffic.
`timescale 1ns / 1ps

module tb_vendor_option_tlv_parser_core;
   import votp_pkg::*;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_ENT,
      PARSE_HDR,
      PARSE_DATA,
      PARSE_SKIP
   } parse_phase_type;

   class option_scoreboard;
      logic [31:0]     want_ent;
      logic [15:0]     max_len;
      logic [7:0]      max_subs;
      parse_phase_type ph;
      logic [15:0]     pos;
      logic [15:0]     total;
      logic [31:0]     ent_sr;
      logic [31:0]     hdr_sr;
      logic [15:0]     remaining;
      logic [7:0]      subs;
      logic [2:0]      err;
      logic            muted;
      rsp_type         pending[$];
      int              errors;

      function new();
         want_ent = '0;
         max_len  = 16'd256;
         max_subs = 8'd16;
         errors   = 0;
         clear();
      endfunction

      function void clear();
         ph        = PARSE_IDLE;
         pos       = '0;
         total     = '0;
         ent_sr    = '0;
         hdr_sr    = '0;
         remaining = '0;
         subs      = '0;
         err       = ST_OK;
         muted     = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_EXPECTED_ENT: want_ent = val;
            CSR_MAX_SUB_LEN:  max_len  = val[15:0];
            CSR_MAX_SUB_OPTS: max_subs = val[7:0];
            default: ;
         endcase
      endfunction

      function void advance_sub();
         if (pos >= total) begin
            ph = PARSE_IDLE;
         end else if (subs >= max_subs || (total - pos) < HDR_BYTES) begin
            ph = PARSE_SKIP;
         end else begin
            ph        = PARSE_HDR;
            hdr_sr    = '0;
            remaining = '0;
         end
      endfunction

      // Advance the parse by one accepted byte and queue the result it causes, if any
      function void note_byte(req_type it);
         rsp_type     r;
         logic [15:0] p;
         logic        last;
         logic        have;
         logic        fin;
         logic [2:0]  st;
         r    = '0;
         last = 1'b0;
         have = 1'b0;
         fin  = 1'b0;
         if (it.start_req) begin
            clear();
            total = it.option_len;
            if (total < HDR_BYTES) begin
               err = ST_SHORT;
               fin = 1'b1;
            end else begin
               ph = PARSE_ENT;
            end
         end
         if (!fin) begin
            if (ph == PARSE_IDLE) return;
            p    = pos;
            pos  = p + 16'd1;
            last = (pos == total);
            case (ph)
               PARSE_ENT: begin
                  ent_sr = {ent_sr[23:0], it.data_byte};
                  if (p == HDR_BYTES - 16'd1) begin
                     if (want_ent != '0 && ent_sr != want_ent) muted = 1'b1;
                     have   = 1'b1;
                     r.kind = KIND_ENT;
                     advance_sub();
                  end
               end
               PARSE_HDR: begin
                  hdr_sr = {hdr_sr[23:0], it.data_byte};
                  remaining++;
                  if (remaining >= HDR_BYTES) begin
                     r.sub_code = hdr_sr[31:16];
                     r.sub_len  = hdr_sr[15:0];
                     // bounds take priority over the size limit
                     if (r.sub_len > total - pos) begin
                        err  = ST_BOUNDS;
                        last = 1'b1;
                     end else if (r.sub_len > max_len) begin
                        err  = ST_TOO_LONG;
                        last = 1'b1;
                     end else begin
                        have        = 1'b1;
                        r.kind      = KIND_HDR;
                        r.sub_index = subs;
                        if (r.sub_len == '0) begin
                           subs++;
                           advance_sub();
                        end else begin
                           remaining = r.sub_len;
                           ph        = PARSE_DATA;
                        end
                     end
                  end
               end
               PARSE_DATA: begin
                  r.sub_code    = hdr_sr[31:16];
                  r.sub_len     = hdr_sr[15:0];
                  r.byte_offset = r.sub_len - remaining;
                  r.sub_index   = subs;
                  r.out_byte    = it.data_byte;
                  r.kind        = KIND_DATA;
                  have          = 1'b1;
                  remaining--;
                  if (remaining == '0) begin
                     subs++;
                     advance_sub();
                  end
               end
               default: ;
            endcase
            fin = last;
         end
         if (fin) begin
            st = (err != ST_OK) ? err : (muted ? ST_MISMATCH : ST_OK);
            if (!have || st != ST_OK) begin
               r      = '0;
               r.kind = KIND_END;
            end
            ph           = PARSE_IDLE;
            r.ent_number = (pos >= HDR_BYTES) ? ent_sr : '0;
            r.done_res   = 1'b1;
            r.status     = st;
            pending.push_back(r);
         end else if (have && !muted) begin
            r.ent_number = ent_sr;
            pending.push_back(r);
         end
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: expected none got %h", $time, got);
            return;
         end
         want = pending.pop_front();
         compare("kind", 32'(want.kind), 32'(got.kind));
         compare("ent_number", want.ent_number, got.ent_number);
         compare("sub_code", 32'(want.sub_code), 32'(got.sub_code));
         compare("sub_len", 32'(want.sub_len), 32'(got.sub_len));
         compare("sub_index", 32'(want.sub_index), 32'(got.sub_index));
         compare("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
         compare("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         compare("done_res", 32'(want.done_res), 32'(got.done_res));
         compare("status", 32'(want.status), 32'(got.status));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   option_scoreboard sb = new();
   bit calm = 1'b0;
   int sent = 0;
   int stall_run = 0;

   vendor_option_tlv_parser_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_run != 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(input logic start, input logic [7:0] data, input logic [15:0] olen);
      req_type it;
      it.start_req  = start;
      it.data_byte  = data;
      it.option_len = olen;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(it);
      sent++;
   endtask

   // First byte carries start and the length; later bytes carry a don't-care length
   task automatic send_payload(input logic [15:0] olen, input logic [7:0] pl[$]);
      for (int i = 0; i < pl.size(); i++)
         send_byte(i == 0, pl[i], (i == 0) ? olen : 16'($urandom));
   endtask

   task automatic send_random_option();
      logic [7:0]  pl[$];
      logic [31:0] ent;
      logic [15:0] code;
      logic [15:0] len;
      logic [15:0] olen;
      int          mode;
      int          nsub;
      int          k;
      mode = $urandom_range(0, 99);
      if (mode < 6) begin
         // loose bytes, random start flags
         repeat ($urandom_range(1, 5))
            send_byte($urandom_range(0, 3) == 0, 8'($urandom),
                      $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 12)));
      end else if (mode < 11) begin
         send_byte(1'b1, 8'($urandom), 16'($urandom_range(1, 3)));
      end else begin
         ent = (sb.want_ent != '0 && $urandom_range(0, 3) != 0) ? sb.want_ent : $urandom;
         for (int j = 3; j >= 0; j--) pl.push_back(ent[8*j +: 8]);
         nsub = $urandom_range(0, 5);
         for (int s = 0; s < nsub; s++) begin
            code = 16'($urandom);
            k    = $urandom_range(0, 19);
            if (k == 0) len = 16'($urandom_range(16'hF000, 16'hFFFF));
            else if (k == 1 && sb.max_len < 16'd8) len = sb.max_len + 16'd1;
            else len = 16'($urandom_range(0, 5));
            pl.push_back(code[15:8]);
            pl.push_back(code[7:0]);
            pl.push_back(len[15:8]);
            pl.push_back(len[7:0]);
            if (len >= 16'hF000) break;
            repeat (len) pl.push_back(8'($urandom));
         end
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) pl.push_back(8'($urandom));
         olen = 16'(pl.size());
         k    = $urandom_range(0, 9);
         if (k == 0 && pl.size() > 4) begin
            // declared length ends early: the bytes past it are ignored
            olen = 16'($urandom_range(4, pl.size() - 1));
         end else if (k == 1 && pl.size() > 1) begin
            // payload cut short: the next start drops it
            repeat ($urandom_range(1, pl.size() - 1)) void'(pl.pop_back());
         end
         send_payload(olen, pl);
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = sent + count;
      while (sent < target) send_random_option();
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
   endtask

   initial begin
      logic [7:0] pl[$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(1'b1, 8'hFF, 16'd1);                 // too short
      send_byte(1'b0, 8'hA5, 16'hFFFF);              // idle byte, ignored
      pl = '{8'h00, 8'h00, 8'h00, 8'h00};            // enterprise only
      send_payload(16'd4, pl);
      send_byte(1'b1, 8'h12, 16'hFFFF);              // largest length, then restart
      send_byte(1'b0, 8'h34, 16'h0000);
      // data sub-option, empty sub-option, then a tail shorter than a header
      pl = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02,
             8'h00, 8'hFF, 8'h00, 8'h07, 8'h00, 8'h00, 8'h5A};
      send_payload(16'd15, pl);

      run_random(150);
      for (int step = 1; step <= 6; step++) begin
         if (step == 6) calm = 1'b1;
         settle();
         case (step)
            1: begin
               write_csr(CSR_EXPECTED_ENT, $urandom);
               write_csr(CSR_MAX_SUB_LEN, {16'($urandom), 16'd0});
               write_csr(CSR_MAX_SUB_OPTS, {24'($urandom), 8'd1});
            end
            2: begin
               write_csr(CSR_EXPECTED_ENT, 32'hFFFF_FFFF);
               write_csr(CSR_MAX_SUB_LEN, {16'($urandom), 16'hFFFF});
               write_csr(CSR_MAX_SUB_OPTS, {24'($urandom), 8'hFF});
            end
            3: begin
               write_csr(CSR_EXPECTED_ENT, 32'd0);
               write_csr(CSR_MAX_SUB_LEN, {16'($urandom), 16'd3});
               write_csr(CSR_MAX_SUB_OPTS, {24'($urandom), 8'd2});
               write_csr(CSR_UNUSED, $urandom);
            end
            4: begin
               write_csr(CSR_EXPECTED_ENT, $urandom);
               write_csr(CSR_MAX_SUB_LEN, {16'($urandom), 16'd8});
               write_csr(CSR_MAX_SUB_OPTS, {24'($urandom), 8'd3});
            end
            5: begin
               write_csr(CSR_EXPECTED_ENT, 32'd0);
               write_csr(CSR_MAX_SUB_LEN, {16'($urandom), 16'($urandom_range(4, 300))});
               write_csr(CSR_MAX_SUB_OPTS, {24'($urandom), 8'($urandom_range(1, 255))});
            end
            default: begin
               write_csr(CSR_EXPECTED_ENT, $urandom);
               write_csr(CSR_MAX_SUB_LEN, {16'($urandom), 16'd5});
               write_csr(CSR_MAX_SUB_OPTS, {24'($urandom), 8'd4});
            end
         endcase
         run_random(210);
      end
      settle();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[vendor_option_tlv_parser_core] OK");
      end else begin
         $display("[vendor_option_tlv_parser_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[vendor_option_tlv_parser_core] ERROR");
      $finish;
   end

endmodule

@@ vendor_option_tlv_parser_core.f @@
design/votp_pkg.sv
design/vendor_option_tlv_parser_core.sv
design/votp_checker.sv
verif/tb_vendor_option_tlv_parser_core.sv
